// File: hw/rtl/rts_pkg.sv
// Shared types and constants for the retransmit slot table.
package rts_pkg;

    localparam int SLOTS   = 8;
    localparam int SLOT_IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SLOT_FW = 3;

    localparam logic [7:0]  REPLY_TOP_BIT = 8'h80;
    localparam logic [7:0]  CONFIG_CLASS  = 8'hC0;
    localparam logic [15:0] MAX_TICK_RST  = 16'd50;
    localparam logic [7:0]  MAX_RETRY_RST = 8'd5;

    typedef enum logic [1:0] {
        KIND_SEND  = 2'd0,
        KIND_REPLY = 2'd1,
        KIND_TICK  = 2'd2,
        KIND_CLEAR = 2'd3
    } t_kind;

    typedef enum logic {
        CFG_MAX_TICK  = 1'b0,
        CFG_MAX_RETRY = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEND,
        S_REPLY,
        S_TICK,
        S_CLEAR,
        S_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic send_write;
        logic reply_step;
        logic tick_step;
        logic idx_inc;
        logic clr_all;
        logic emit_resend;
        logic emit_close;
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_free;
        logic idx_last;
        logic tick_resend;
        logic tick_fault;
    } t_dp_stat;

endpackage

// File: hw/rtl/rts_ifs.sv
// Request, result and configuration channel interfaces.
interface rts_req_if;
    import rts_pkg::*;
    logic        valid;
    logic        ready;
    t_kind       kind;
    logic [7:0]  pkt_type;
    logic [15:0] chan_id;
    logic [15:0] channel_num;
    logic        has_payload;
    modport source (output valid, kind, pkt_type, chan_id, channel_num, has_payload,
                    input ready);
    modport sink   (input valid, kind, pkt_type, chan_id, channel_num, has_payload,
                    output ready);
endinterface

interface rts_res_if;
    import rts_pkg::*;
    logic               valid;
    logic               ready;
    logic               accepted;
    logic [SLOT_FW-1:0] slot;
    logic               resend;
    logic               fault;
    logic               free_slot;
    logic               waiting_any;
    logic               last;
    modport source (output valid, accepted, slot, resend, fault, free_slot, waiting_any,
                    last, input ready);
    modport sink   (input valid, accepted, slot, resend, fault, free_slot, waiting_any,
                    last, output ready);
endinterface

interface rts_cfg_if;
    import rts_pkg::*;
    logic        valid;
    logic        ready;
    t_cfg_idx    index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/rts_ctrl.sv
// Sequencer: walks the slot table for reply and tick requests and schedules results.
module rts_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  rts_pkg::t_kind    i_kind,
    input  rts_pkg::t_dp_stat i_stat,
    output logic              o_in_ready,
    output rts_pkg::t_ctrl_cmd o_cmd
);
    import rts_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_kind)
                        KIND_SEND:  n_state = S_SEND;
                        KIND_REPLY: n_state = S_REPLY;
                        KIND_TICK:  n_state = S_TICK;
                        KIND_CLEAR: n_state = S_CLEAR;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_SEND:  n_state = S_FIN;
            S_CLEAR: n_state = S_FIN;
            S_REPLY: begin
                if (i_stat.idx_last) n_state = S_FIN;
            end
            S_TICK: begin
                if (i_stat.tick_fault) begin
                    n_state = S_FIN;
                end else if (i_stat.tick_resend && !i_stat.out_free) begin
                    n_state = S_TICK;
                end else if (i_stat.idx_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_SEND:  o_cmd.send_write = 1'b1;
            S_CLEAR: o_cmd.clr_all    = 1'b1;
            S_REPLY: begin
                o_cmd.reply_step = 1'b1;
                o_cmd.idx_inc    = 1'b1;
            end
            S_TICK: begin
                // a resend result needs the output register; hold the slot until then
                if (!(i_stat.tick_resend && !i_stat.out_free)) begin
                    o_cmd.tick_step   = 1'b1;
                    o_cmd.idx_inc     = !i_stat.tick_fault;
                    o_cmd.emit_resend = i_stat.tick_resend;
                end
            end
            S_FIN:   o_cmd.emit_close = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// File: hw/rtl/rts_dp.sv
// Slot table, configuration registers, scan index and result register.
module rts_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    rts_req_if.sink            i_req,
    rts_cfg_if.sink            i_cfg,
    rts_res_if.source          o_res,
    input  rts_pkg::t_ctrl_cmd i_cmd,
    output rts_pkg::t_dp_stat  o_stat
);
    import rts_pkg::*;

    logic [15:0] r_max_tick;
    logic [7:0]  r_max_retry;

    // held request fields
    logic [7:0]  r_pkt_type;
    logic [15:0] r_chan_id;
    logic [15:0] r_channel;
    logic        r_has_pay;

    logic [SLOTS-1:0] r_waiting;
    logic [7:0]       r_type    [SLOTS];
    logic [15:0]      r_chid    [SLOTS];
    logic [15:0]      r_chan    [SLOTS];
    logic             r_pay     [SLOTS];
    logic [15:0]      r_ticks   [SLOTS];
    logic [7:0]       r_retries [SLOTS];

    logic [SLOT_IW-1:0] r_idx;

    // closing result fields
    logic               r_acc;
    logic [SLOT_FW-1:0] r_slot;
    logic               r_fault;

    logic               r_out_valid;
    logic               r_o_acc;
    logic [SLOT_FW-1:0] r_o_slot;
    logic               r_o_resend;
    logic               r_o_fault;
    logic               r_o_free;
    logic               r_o_wait;
    logic               r_o_last;

    logic [SLOT_IW-1:0] first_free;
    logic               any_free;
    logic               reply_match;
    logic [15:0]        tick_dec;
    logic [7:0]         retry_dec;
    logic               expired;
    logic               out_free;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_tick  <= MAX_TICK_RST;
            r_max_retry <= MAX_RETRY_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_MAX_TICK:  r_max_tick  <= i_cfg.data;
                CFG_MAX_RETRY: r_max_retry <= i_cfg.data[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        first_free = '0;
        any_free   = 1'b0;
        for (int k = SLOTS - 1; k >= 0; k--) begin
            if (!r_waiting[k]) begin
                first_free = SLOT_IW'(k);
                any_free   = 1'b1;
            end
        end
    end

    // bit 7 of the stored type is masked; config-class commands with data also check channel
    always_comb begin
        reply_match = r_waiting[r_idx]
                   && (r_pkt_type == (r_type[r_idx] & ~REPLY_TOP_BIT))
                   && (r_chan_id == r_chid[r_idx])
                   && !(((r_type[r_idx] & CONFIG_CLASS) == CONFIG_CLASS)
                        && r_pay[r_idx] && (r_channel != r_chan[r_idx]));
    end

    assign tick_dec  = (r_ticks[r_idx] == '0) ? '0 : r_ticks[r_idx] - 16'd1;
    assign retry_dec = (r_retries[r_idx] == '0) ? '0 : r_retries[r_idx] - 8'd1;
    assign expired   = r_waiting[r_idx] && (tick_dec == '0);
    assign out_free  = !r_out_valid || o_res.ready;

    assign o_stat.out_free    = out_free;
    assign o_stat.idx_last    = (r_idx == SLOT_IW'(SLOTS - 1));
    assign o_stat.tick_resend = expired && (retry_dec != '0);
    assign o_stat.tick_fault  = expired && (retry_dec == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pkt_type <= i_req.pkt_type;
            r_chan_id  <= i_req.chan_id;
            r_channel  <= i_req.channel_num;
            r_has_pay  <= i_req.has_payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_acc   <= 1'b0;
            r_slot  <= '0;
            r_fault <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_idx   <= '0;
                r_acc   <= 1'b0;
                r_slot  <= '0;
                r_fault <= 1'b0;
            end else if (i_cmd.idx_inc && !o_stat.idx_last) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.send_write && any_free) begin
                r_acc  <= 1'b1;
                r_slot <= SLOT_FW'(first_free);
            end
            if (i_cmd.tick_step && o_stat.tick_fault) begin
                r_fault <= 1'b1;
                r_slot  <= SLOT_FW'(r_idx);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waiting <= '0;
        end else if (i_cmd.clr_all) begin
            r_waiting <= '0;
        end else if (i_cmd.send_write && any_free) begin
            r_waiting[first_free] <= 1'b1;
        end else if (i_cmd.reply_step && reply_match) begin
            r_waiting[r_idx] <= 1'b0;
        end
    end

    // counters are only read while a slot waits, and a send always arms them
    always_ff @(posedge i_clk) begin
        if (i_cmd.send_write && any_free) begin
            r_type[first_free]    <= r_pkt_type;
            r_chid[first_free]    <= r_chan_id;
            r_chan[first_free]    <= r_channel;
            r_pay[first_free]     <= r_has_pay;
            r_ticks[first_free]   <= r_max_tick;
            r_retries[first_free] <= r_max_retry;
        end else if (i_cmd.tick_step && r_waiting[r_idx]) begin
            if (!expired) begin
                r_ticks[r_idx] <= tick_dec;
            end else if (retry_dec != '0) begin
                r_ticks[r_idx]   <= r_max_tick;
                r_retries[r_idx] <= retry_dec;
            end else begin
                r_ticks[r_idx]   <= '0;
                r_retries[r_idx] <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_resend || i_cmd.emit_close) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_resend) begin
            r_o_acc    <= 1'b0;
            r_o_slot   <= SLOT_FW'(r_idx);
            r_o_resend <= 1'b1;
            r_o_fault  <= 1'b0;
            r_o_free   <= ~&r_waiting;
            r_o_wait   <= |r_waiting;
            r_o_last   <= 1'b0;
        end else if (i_cmd.emit_close) begin
            r_o_acc    <= r_acc;
            r_o_slot   <= r_slot;
            r_o_resend <= 1'b0;
            r_o_fault  <= r_fault;
            r_o_free   <= ~&r_waiting;
            r_o_wait   <= |r_waiting;
            r_o_last   <= 1'b1;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.accepted    = r_o_acc;
    assign o_res.slot        = r_o_slot;
    assign o_res.resend      = r_o_resend;
    assign o_res.fault       = r_o_fault;
    assign o_res.free_slot   = r_o_free;
    assign o_res.waiting_any = r_o_wait;
    assign o_res.last        = r_o_last;

endmodule

// File: hw/rtl/reply_tracked_retransmit_slots_core.sv
// Top level of the reply-tracked retransmit slot table.
//
//  channel  | dir | handshake     | carries
//  ---------+-----+---------------+------------------------------------------
//  i_req    | in  | valid/ready   | kind, pkt_type, chan_id, channel_num, ...
//  o_res    | out | valid/ready   | accepted, slot, resend, fault, flags, last
//  i_cfg    | in  | valid/ready   | index (0 tick limit, 1 retry limit), data
//
// Send and clear requests pass through their working state and the finish
// state; reply and tick requests walk the table one slot per cycle, set by
// the single slot port. A tick that faults stops at that slot.
// Each resend result stalls the walk while the output register is occupied.
// One request at a time; the next is taken while the final result waits.
// Reset (synchronous) frees every slot and restores the limits to 50 and 5.
module reply_tracked_retransmit_slots_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rts_req_if.sink   i_req,
    rts_cfg_if.sink   i_cfg,
    rts_res_if.source o_res
);
    import rts_pkg::*;

    t_ctrl_cmd cmd;
    t_dp_stat  stat;
    logic      in_ready;

    assign i_req.ready = in_ready;

    rts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_kind     (i_req.kind),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    rts_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cfg   (i_cfg),
        .o_res   (o_res),
        .i_cmd   (cmd),
        .o_stat  (stat)
    );

endmodule
